### rtl/rm_pkg.sv
// Package for the running median: sizes, payload types and cell control.
`default_nettype none
package rm_pkg;

    localparam int CAPACITY    = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int MEDIAN_BITS = SAMPLE_BITS + 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int GROUP       = 8;
    localparam int NGROUPS     = (CAPACITY + GROUP - 1) / GROUP;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [MEDIAN_BITS-1:0] t_median;

    typedef struct packed {
        logic    restart;
        t_sample sample;
    } t_in_item;

    typedef struct packed {
        t_median          median_x2;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_out_item;

    // per-cell write control for one insertion
    typedef struct packed {
        logic en;      // insertion happens this cycle
        logic in_use;  // cell holds a live entry
        logic at_end;  // cell is the first free slot
    } t_cell_ctl;

endpackage
`default_nettype wire

### rtl/rm_cell.sv
// One cell of the sorted chain: holds one entry, shifts right on insertion.
`default_nettype none
module rm_cell
    import rm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_sample   i_x,
    input  wire t_sample   i_left_val,
    input  wire logic      i_left_lt,
    output t_sample        o_val,
    output logic           o_lt
);

    t_sample r_val;
    t_sample n_val;
    logic    w_write;

    // new sample sorts below this entry
    assign o_lt = i_x < r_val;

    // a live entry above the sample moves up; the free slot takes the last one
    assign w_write = i_ctl.en && (i_ctl.at_end || (i_ctl.in_use && o_lt));
    assign n_val   = i_left_lt ? i_left_val : i_x;

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

### rtl/rm_reduce.sv
// Two-stage registered select of the two middle entries and their sum.
`default_nettype none
module rm_reduce
    import rm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_adv,
    input  wire t_sample          i_vals [CAPACITY],
    input  wire logic [IDX_W-1:0] i_lo,
    input  wire logic [IDX_W-1:0] i_hi,
    output t_median               o_sum
);

    logic [SAMPLE_BITS-1:0] r_glo [NGROUPS];
    logic [SAMPLE_BITS-1:0] r_ghi [NGROUPS];
    logic [SAMPLE_BITS-1:0] n_glo [NGROUPS];
    logic [SAMPLE_BITS-1:0] n_ghi [NGROUPS];
    logic [SAMPLE_BITS-1:0] w_lo;
    logic [SAMPLE_BITS-1:0] w_hi;
    t_median                r_sum;

    // one-hot masked OR inside each group of cells
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            n_glo[g] = '0;
            n_ghi[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    if (i_lo == IDX_W'(g * GROUP + k)) begin
                        n_glo[g] = n_glo[g] | i_vals[g * GROUP + k];
                    end
                    if (i_hi == IDX_W'(g * GROUP + k)) begin
                        n_ghi[g] = n_ghi[g] | i_vals[g * GROUP + k];
                    end
                end
            end
        end
    end

    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            w_lo = w_lo | r_glo[g];
            w_hi = w_hi | r_ghi[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_glo <= n_glo;
            r_ghi <= n_ghi;
            r_sum <= t_median'($signed({w_lo[SAMPLE_BITS-1], w_lo}))
                   + t_median'($signed({w_hi[SAMPLE_BITS-1], w_hi}));
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

### rtl/running_median.sv
// Top level of the running median: sorted cell chain, select pipeline, handshakes.
//
// Usage: each input request carries a restart flag and a signed sample. The
// sample is inserted at the accepting edge into a chain of CAPACITY cells that all
// compare against it in parallel and shift larger entries one place up.
// Restart empties the chain first. A full chain drops the sample and flags
// overflow. Every input request yields exactly one result request holding
// twice the median (sum of the two middle entries), the held count and the
// overflow flag.
// The result becomes valid after the sample is inserted at the accepting
// edge and the group select and then the final select and add are registered.
// Throughput: one request per cycle while the receiver does not stall; the
// cell chain can insert every cycle and the select tree is pipelined.
// When the receiver stalls with a result pending, the whole pipeline holds
// and input ready drops in the same cycle. Reset clears the held count and
// all valid flags; cell contents are left as they are and are never read
// before being written.
`default_nettype none
module running_median
    import rm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    logic             w_adv;
    logic             w_accept;
    logic [CNT_W-1:0] w_base;
    logic             w_full;
    logic [CNT_W-1:0] w_n;
    logic [CNT_W-1:0] w_n_m1;

    logic [CNT_W-1:0] r_count;
    logic             r_v0, r_v1, r_out_valid;
    logic [IDX_W-1:0] r_lo0, r_hi0;
    logic [CNT_W-1:0] r_cnt0, r_cnt1, r_cnt2;
    logic             r_ovf0, r_ovf1, r_ovf2;

    t_sample          w_val [CAPACITY];
    logic             w_lt  [CAPACITY];
    t_median          w_sum;

    assign w_adv      = !(r_out_valid && !i_out_ready);
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    assign w_base = i_in.restart ? '0 : r_count;
    assign w_full = (w_base == CNT_W'(CAPACITY));
    assign w_n    = w_full ? w_base : w_base + CNT_W'(1);
    assign w_n_m1 = w_n - CNT_W'(1);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctl w_ctl;
        t_sample   w_left_val;
        logic      w_left_lt;

        assign w_ctl.en     = w_accept && !w_full;
        assign w_ctl.in_use = (CNT_W'(i) < w_base);
        assign w_ctl.at_end = (CNT_W'(i) == w_base);

        if (i == 0) begin : g_first
            assign w_left_val = '0;
            assign w_left_lt  = 1'b0;
        end else begin : g_rest
            assign w_left_val = w_val[i-1];
            assign w_left_lt  = w_lt[i-1];
        end

        rm_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_x        (i_in.sample),
            .i_left_val (w_left_val),
            .i_left_lt  (w_left_lt),
            .o_val      (w_val[i]),
            .o_lt       (w_lt[i])
        );
    end

    rm_reduce u_reduce (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_vals (w_val),
        .i_lo   (r_lo0),
        .i_hi   (r_hi0),
        .o_sum  (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            if (w_accept) begin
                r_count <= w_n;
            end
            r_v0        <= w_accept;
            r_v1        <= r_v0;
            r_out_valid <= r_v1;
        end
    end

    // middle indices: hi = n/2, lo = (n-1)/2; equal for an odd count
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lo0  <= w_n_m1[IDX_W:1];
            r_hi0  <= w_n[IDX_W:1];
            r_cnt0 <= w_n;
            r_ovf0 <= w_full;
            r_cnt1 <= r_cnt0;
            r_ovf1 <= r_ovf0;
            r_cnt2 <= r_cnt1;
            r_ovf2 <= r_ovf1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out.median_x2 = w_sum;
    assign o_out.count     = r_cnt2;
    assign o_out.overflow  = r_ovf2;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.count != '0)
        else $error("result with empty store");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.overflow) |-> o_out.count == CNT_W'(CAPACITY))
        else $error("overflow without full store");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.restart) |=> r_count == CNT_W'(1))
        else $error("restart did not leave one entry");

endmodule
`default_nettype wire
